// File: src/wildcard_pattern_matcher_defines.svh
// ----------------------------------------------------------------------------
// wildcard pattern matcher assertion macros
// shared assertion forms, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef WILDCARD_PATTERN_MATCHER_DEFINES_SVH
`define WILDCARD_PATTERN_MATCHER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define WPM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define WPM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg
// item types, mode codes and wildcard bytes for the wildcard pattern matcher
// ----------------------------------------------------------------------------
package wpm_pkg;

	// default pattern capacity in bytes
	localparam int unsigned PATTERN_MAX_DEF = 32;

	// mode codes of an input item
	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_APPEND = 2'd1;
	localparam logic [1:0] MODE_TEXT   = 2'd2;
	localparam logic [1:0] MODE_FINISH = 2'd3;

	// wildcard bytes of the pattern
	localparam logic [7:0] STAR_BYTE = 8'h2A;
	localparam logic [7:0] ANY_BYTE  = 8'h3F;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] symbol;
	} wpm_in_t;

	typedef struct packed {
		logic match;
		logic error;
	} wpm_out_t;

endpackage

// File: src/wildcard_pattern_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher
// whole-string matcher with '?' and '*' wildcards over a streamed text
// ----------------------------------------------------------------------------
// A clear item starts a match, pattern items append up to PATTERN_MAX bytes,
// text items stream one byte each and a finish item returns one result with
// the match bit and a sticky error bit (pattern overflow or pattern after
// text; match reads 0 then). Every item passes the input register and then
// the column update, so the block accepts an item in every cycle while no
// finish item waits on a stalled output, and a finish result is captured in
// the result register after the input register; the throughput limit is the
// combinational update of the PATTERN_MAX+1 bit match column, whose star
// ripple is a log2(PATTERN_MAX+1) level prefix scan. Only a finish item needs
// the result register, so only finish items wait on a stalled output.
`include "wildcard_pattern_matcher_defines.svh"

module wildcard_pattern_matcher #(
	parameter int unsigned PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  wpm_pkg::wpm_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output wpm_pkg::wpm_out_t out_data
);
	import wpm_pkg::*;

	localparam int unsigned COL_W = PATTERN_MAX + 1;
	localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);

	wpm_in_t          item_s1;
	logic             valid_s1;
	logic [7:0]       pattern_q [PATTERN_MAX];
	logic [LEN_W-1:0] len_q;
	logic [COL_W-1:0] col_q;
	logic             text_q;
	logic             error_q;
	logic             out_valid_q;
	wpm_out_t         out_data_q;

	logic             advance;
	logic             is_finish;
	logic             full;
	logic             append_ok;
	logic [COL_W-1:0] col_text;
	logic [COL_W-1:0] col_app;

	// handshake: finish items need a free result slot
	assign is_finish = (item_s1.mode == MODE_FINISH);
	assign advance   = valid_s1 && (!is_finish || !out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign full      = (len_q == LEN_W'(PATTERN_MAX));
	assign append_ok = (item_s1.mode == MODE_APPEND) && !text_q && !full;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// column after a text byte
	wpm_column #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_column (
		.col      (col_q),
		.len      (len_q),
		.pattern  (pattern_q),
		.symbol   (item_s1.symbol),
		.col_next (col_text)
	);

	// column after a pattern byte: new row copies the last row through a star
	always_comb begin
		col_app = col_q;
		for (int i = 1; i <= int'(PATTERN_MAX); i++) begin
			if (len_q == LEN_W'(i - 1)) begin
				col_app[i] = (item_s1.symbol == STAR_BYTE) ? col_q[len_q] : 1'b0;
			end
		end
	end

	// pattern store, written at the current length
	always_ff @(posedge clk) begin
		if (advance && append_ok) begin
			for (int i = 0; i < int'(PATTERN_MAX); i++) begin
				if (len_q == LEN_W'(i)) begin
					pattern_q[i] <= item_s1.symbol;
				end
			end
		end
	end

	// match state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			col_q   <= COL_W'(1);
			text_q  <= 1'b0;
			error_q <= 1'b0;
		end else if (advance) begin
			unique case (item_s1.mode)
				MODE_CLEAR: begin
					len_q   <= '0;
					col_q   <= COL_W'(1);
					text_q  <= 1'b0;
					error_q <= 1'b0;
				end
				MODE_APPEND: begin
					if (append_ok) begin
						col_q <= col_app;
						len_q <= len_q + LEN_W'(1);
					end else begin
						error_q <= 1'b1;
					end
				end
				MODE_TEXT: begin
					col_q  <= col_text;
					text_q <= 1'b1;
				end
				MODE_FINISH: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_finish) begin
			out_data_q.match <= !error_q && col_q[len_q];
			out_data_q.error <= error_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// checks
	`WPM_ASSERT_NOW(a_len_bound, 1'b1, len_q <= LEN_W'(PATTERN_MAX), "pattern length over capacity")
	`WPM_ASSERT_NOW(a_err_no_match, out_valid_q && out_data_q.error, !out_data_q.match, "match with error")
	`WPM_ASSERT_NEXT(a_late_pattern, advance && item_s1.mode == MODE_APPEND && text_q, error_q, "late pattern byte without error")
	`WPM_ASSERT_NEXT(a_finish_result, advance && is_finish, out_valid_q && out_data_q.error == $past(error_q), "finish item lost")
	`WPM_ASSERT_NEXT(a_no_spurious, advance && !is_finish && !out_valid_q, !out_valid_q, "result without finish")

endmodule

// File: src/wpm_column.sv
// ----------------------------------------------------------------------------
// wpm_column
// next match column for one text byte; the ripple through star rows is
// computed as a parallel prefix scan over (generate, propagate) pairs
// ----------------------------------------------------------------------------
module wpm_column #(
	parameter int unsigned PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
	input  logic [PATTERN_MAX:0]               col,
	input  logic [$clog2(PATTERN_MAX+1)-1:0]   len,
	input  logic [7:0]                         pattern [PATTERN_MAX],
	input  logic [7:0]                         symbol,
	output logic [PATTERN_MAX:0]               col_next
);
	import wpm_pkg::*;

	localparam int unsigned COL_W = PATTERN_MAX + 1;
	localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int unsigned LVL   = $clog2(COL_W);

	logic [COL_W-1:0] g_l [LVL+1];
	logic [COL_W-1:0] p_l [LVL+1];

	// per-row generate and propagate, then log-depth scan
	always_comb begin
		int d;
		d = 1;
		g_l[0] = '0;
		p_l[0] = '0;
		// row zero always drops once a text byte arrives
		for (int i = 1; i <= int'(PATTERN_MAX); i++) begin
			if (LEN_W'(i) <= len) begin
				if (pattern[i-1] == STAR_BYTE) begin
					g_l[0][i] = col[i];
					p_l[0][i] = 1'b1;
				end else if (pattern[i-1] == ANY_BYTE || pattern[i-1] == symbol) begin
					g_l[0][i] = col[i-1];
				end
			end
		end
		for (int l = 0; l < int'(LVL); l++) begin
			d = 1 << l;
			for (int i = 0; i < int'(COL_W); i++) begin
				if (i >= d) begin
					g_l[l+1][i] = g_l[l][i] | (p_l[l][i] & g_l[l][i-d]);
					p_l[l+1][i] = p_l[l][i] & p_l[l][i-d];
				end else begin
					g_l[l+1][i] = g_l[l][i];
					p_l[l+1][i] = p_l[l][i];
				end
			end
		end
		col_next = g_l[LVL];
	end

endmodule
